### rtl/core/letter_trie_engine_defines.svh
// Assertion macros shared by the letter trie engine RTL.
// Expects a clock named clock and a synchronous active-high reset named reset in scope.
`ifndef LETTER_TRIE_ENGINE_DEFINES_SVH
`define LETTER_TRIE_ENGINE_DEFINES_SVH

// Property checked at every edge outside reset.
`define LTE_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent, outside reset.
`define LTE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/lte_pkg.sv
// Package for the letter trie engine: pool sizes, field types, node row layout.
// No dependencies; imported by lte_row_ram, letter_trie_engine and the testbench.
`timescale 1ns / 1ps

package lte_pkg;

   localparam int NODES    = 1024;
   localparam int ALPHABET = 26;
   localparam int NODE_W   = $clog2(NODES);
   localparam int USED_W   = $clog2(NODES + 1);
   localparam int LETTER_W = 5;
   localparam int OP_W     = 2;

   typedef logic [OP_W-1:0]     op_type;
   typedef logic [LETTER_W-1:0] letter_type;
   typedef logic [NODE_W-1:0]   node_type;
   typedef logic [USED_W-1:0]   used_type;

   localparam op_type OP_INSERT = OP_W'(0);
   localparam op_type OP_SEARCH = OP_W'(1);

   // One node: its child link for every letter plus its own end-of-word mark.
   typedef struct packed {
      logic                     end_mark;
      node_type [ALPHABET-1:0]  links;
   } row_type;

   typedef struct packed {
      logic     en;
      node_type addr;
      row_type  row;
   } wr_type;

endpackage

### rtl/core/letter_trie_engine.sv
// Channel | Role   | Handshake            | Payload
// req     | input  | req_valid/req_stall  | req_op, req_letter, req_empty_word, req_last
// rsp     | output | rsp_valid/rsp_stall  | rsp_answer, rsp_out_of_nodes
//
// A letter that does not end its word gets a row read in S_IDLE, then the step in S_STEP.
// A final item of an insert or search whose walk stayed on the path also goes to S_FIN,
// since the end node's row is read again for its mark.
// The registered read of the synchronous node row memory sets these steps.
// After reset the node memory is cleared one row a cycle, all NODES (1024) rows,
// with req_stall high throughout. A stalled response holds back only answering steps.
// Top level of the letter trie engine; uses lte_pkg, lte_row_ram and the assertion macros.
`timescale 1ns / 1ps
`include "letter_trie_engine_defines.svh"

module letter_trie_engine (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  lte_pkg::op_type      req_op,
   input  lte_pkg::letter_type  req_letter,
   input  logic                 req_empty_word,
   input  logic                 req_last,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_answer,
   output logic                 rsp_out_of_nodes
);
   import lte_pkg::*;

   typedef enum logic [3:0] {
      S_CLEAR = 4'b0001,
      S_IDLE  = 4'b0010,
      S_STEP  = 4'b0100,
      S_FIN   = 4'b1000
   } state_type;

   state_type  state_ff, state_in;
   op_type     op_ff;
   letter_type letter_ff;
   logic       empty_ff, last_ff;
   node_type   current_node_ff, current_node_in;
   logic       path_missed_ff, path_missed_in;
   used_type   nodes_used_ff, nodes_used_in;
   node_type   clr_addr_ff, clr_addr_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_answer_ff, rsp_answer_in;
   logic       rsp_oon_ff, rsp_oon_in;

   wr_type     wr;
   logic       rd_en;
   node_type   rd_addr;
   row_type    rd_row;
   row_type    step_row;
   row_type    mark_row;

   logic       accept;
   logic       rsp_free;
   logic       in_range;
   letter_type slot;
   node_type   link;
   logic       link_ok;
   logic       step_en;
   logic       alloc;
   node_type   walk_node;
   logic       walk_missed;
   logic       final_item;
   logic       need_fin;
   logic       step_rsp;
   logic       step_go;
   logic       fin_go;
   logic       rsp_load;

   lte_row_ram u_row_ram (
      .clock   (clock),
      .wr      (wr),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_row  (rd_row)
   );

   assign accept   = (state_ff == S_IDLE) && req_valid;
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   // Walk step on the row of the current node.
   assign in_range    = letter_ff < LETTER_W'(ALPHABET);
   assign slot        = in_range ? letter_ff : '0;
   assign link        = rd_row.links[slot];
   assign link_ok     = (link != '0) && ({1'b0, link} < USED_W'(NODES));
   assign step_en     = !empty_ff && in_range && !path_missed_ff;
   assign alloc       = step_en && !link_ok && (op_ff == OP_INSERT)
                        && (nodes_used_ff < USED_W'(NODES));
   assign walk_node   = (step_en && link_ok) ? link :
                        alloc ? nodes_used_ff[NODE_W-1:0] : current_node_ff;
   assign walk_missed = path_missed_ff || (step_en && !link_ok && !alloc);

   assign final_item = empty_ff || last_ff;
   assign need_fin   = final_item && !walk_missed
                       && ((op_ff == OP_INSERT) || (op_ff == OP_SEARCH));
   assign step_rsp   = final_item && !need_fin;
   assign step_go    = !step_rsp || rsp_free;
   assign fin_go     = rsp_free;

   always_comb begin
      step_row             = rd_row;
      step_row.links[slot] = nodes_used_ff[NODE_W-1:0];
      mark_row             = rd_row;
      mark_row.end_mark    = 1'b1;
   end

   always_comb begin
      state_in        = state_ff;
      current_node_in = current_node_ff;
      path_missed_in  = path_missed_ff;
      nodes_used_in   = nodes_used_ff;
      clr_addr_in     = clr_addr_ff;
      rsp_load        = 1'b0;
      rsp_answer_in   = rsp_answer_ff;
      rsp_oon_in      = rsp_oon_ff;
      wr.en           = 1'b0;
      wr.addr         = current_node_ff;
      wr.row          = step_row;
      rd_en           = 1'b0;
      rd_addr         = current_node_ff;

      unique case (state_ff)
         S_CLEAR: begin
            wr.en       = 1'b1;
            wr.addr     = clr_addr_ff;
            wr.row      = '0;
            clr_addr_in = clr_addr_ff + NODE_W'(1);
            if (clr_addr_ff == NODE_W'(NODES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            rd_en = accept;
            if (accept) begin
               state_in = S_STEP;
            end
         end
         S_STEP: begin
            if (step_go) begin
               wr.en         = alloc;
               nodes_used_in = nodes_used_ff + used_type'(alloc);
               if (need_fin) begin
                  rd_en           = 1'b1;
                  rd_addr         = walk_node;
                  current_node_in = walk_node;
                  path_missed_in  = 1'b0;
                  state_in        = S_FIN;
               end else if (final_item) begin
                  rsp_load        = 1'b1;
                  case (op_ff)
                     OP_INSERT: begin
                        rsp_answer_in = 1'b0;
                        rsp_oon_in    = walk_missed;
                     end
                     OP_SEARCH: begin
                        rsp_answer_in = 1'b0;
                        rsp_oon_in    = 1'b0;
                     end
                     default: begin
                        rsp_answer_in = !walk_missed;
                        rsp_oon_in    = 1'b0;
                     end
                  endcase
                  current_node_in = '0;
                  path_missed_in  = 1'b0;
                  state_in        = S_IDLE;
               end else begin
                  current_node_in = walk_node;
                  path_missed_in  = walk_missed;
                  state_in        = S_IDLE;
               end
            end
         end
         S_FIN: begin
            if (fin_go) begin
               wr.en           = (op_ff == OP_INSERT);
               wr.row          = mark_row;
               rsp_load        = 1'b1;
               rsp_answer_in   = (op_ff == OP_SEARCH) && rd_row.end_mark;
               rsp_oon_in      = 1'b0;
               current_node_in = '0;
               path_missed_in  = 1'b0;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_CLEAR;
         current_node_ff <= '0;
         path_missed_ff  <= 1'b0;
         nodes_used_ff   <= used_type'(1);
         clr_addr_ff     <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         current_node_ff <= current_node_in;
         path_missed_ff  <= path_missed_in;
         nodes_used_ff   <= nodes_used_in;
         clr_addr_ff     <= clr_addr_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // Capture the item on transfer; hold the response payload while it waits.
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff     <= req_op;
         letter_ff <= req_letter;
         empty_ff  <= req_empty_word;
         last_ff   <= req_last;
      end
      if (rsp_load) begin
         rsp_answer_ff <= rsp_answer_in;
         rsp_oon_ff    <= rsp_oon_in;
      end
   end

   assign req_stall        = (state_ff != S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_answer       = rsp_answer_ff;
   assign rsp_out_of_nodes = rsp_oon_ff;

   `LTE_ASSERT(a_no_rw_same_row, !(rd_en && wr.en && (rd_addr == wr.addr)),
      "read and write hit the same row")
   `LTE_ASSERT_NEXT(a_alloc_counts, (state_ff == S_STEP) && wr.en,
      nodes_used_ff == $past(nodes_used_ff) + used_type'(1),
      "allocation did not advance the node count")
   `LTE_ASSERT(a_pool_bounds,
      (nodes_used_ff != '0) && (nodes_used_ff <= USED_W'(NODES)),
      "node count out of range")
   `LTE_ASSERT_NEXT(a_word_restarts, rsp_load,
      (current_node_ff == '0) && !path_missed_ff,
      "walk not back at the root after a result")

endmodule

### rtl/core/lte_row_ram.sv
// Node row memory of the letter trie engine: one write port, one registered read port.
// Depends on lte_pkg for the row layout and node index width.
`timescale 1ns / 1ps

module lte_row_ram (
   input  logic            clock,
   input  lte_pkg::wr_type wr,
   input  logic            rd_en,
   input  lte_pkg::node_type rd_addr,
   output lte_pkg::row_type  rd_row
);
   import lte_pkg::*;

   row_type rows_ff [NODES];
   row_type rd_row_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         rows_ff[wr.addr] <= wr.row;
      end
   end

   // Hold read data until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_row_ff <= rows_ff[rd_addr];
      end
   end

   assign rd_row = rd_row_ff;

endmodule

### bench/testbench.sv
// Self-checking bench for letter_trie_engine: streams words, predicts each answer.
// Depends on lte_pkg and the letter_trie_engine RTL; reads no files.
`timescale 1ns / 1ps

module testbench;
   import lte_pkg::*;

   localparam op_type OP_PREFIX = OP_W'(2);
   localparam op_type OP_SPARE  = OP_W'(3);
   localparam int     MAX_WORD  = 16;
   localparam int     BANK_SIZE = 64;

   typedef struct packed {
      logic answer;
      logic out_of_nodes;
   } answer_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   op_type     req_op = OP_INSERT;
   letter_type req_letter = '0;
   logic       req_empty_word = 1'b0;
   logic       req_last = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_answer;
   logic       rsp_out_of_nodes;

   // Predicted trie contents and walk position.
   node_type    link_mem [NODES*ALPHABET];
   logic        end_mem [NODES];
   int unsigned used_count;
   node_type    cur_node;
   bit          walk_missed;

   answer_type  pending_answers [$];
   int          mismatches = 0;
   int          items_sent = 0;
   bit          calm = 1'b0;

   // Word scratch and a bank of inserted words for later queries.
   letter_type  word_buf [MAX_WORD];
   int          word_len;
   letter_type  bank_letters [BANK_SIZE][MAX_WORD];
   int          bank_len [BANK_SIZE];
   int          bank_count = 0;

   int          stall_run = 0;
   bit          stall_on = 1'b0;

   letter_trie_engine uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_op           (req_op),
      .req_letter       (req_letter),
      .req_empty_word   (req_empty_word),
      .req_last         (req_last),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_answer       (rsp_answer),
      .rsp_out_of_nodes (rsp_out_of_nodes)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Advance the predicted walk by one item; return 1 when the word ends here.
   function automatic bit trie_walk(op_type op, letter_type lt, logic emp, logic lst,
                                    output answer_type res);
      int       slot;
      node_type nxt;
      res = '0;
      if (!emp && lt < ALPHABET && !walk_missed) begin
         slot = int'(cur_node) * ALPHABET + int'(lt);
         nxt = link_mem[slot];
         if (nxt != '0) begin
            cur_node = nxt;
         end else if (op == OP_INSERT && used_count < NODES) begin
            link_mem[slot] = node_type'(used_count);
            cur_node = node_type'(used_count);
            used_count++;
         end else begin
            walk_missed = 1'b1;
         end
      end
      if (!(emp || lst)) return 1'b0;
      case (op)
         OP_INSERT: begin
            if (walk_missed) res.out_of_nodes = 1'b1;
            else end_mem[cur_node] = 1'b1;
         end
         OP_SEARCH: begin
            res.answer = !walk_missed && end_mem[cur_node];
         end
         default: begin
            res.answer = !walk_missed;
         end
      endcase
      cur_node = '0;
      walk_missed = 1'b0;
      return 1'b1;
   endfunction

   task automatic report_mismatch(string what);
      $display("MISMATCH at %0t: %s", $time, what);
      mismatches++;
   endtask

   // Present one item, hold it until the transfer, then idle for a random gap unless calm.
   task automatic send_item(op_type op, letter_type lt, logic emp, logic lst);
      answer_type res;
      int         gap;
      req_op         <= op;
      req_letter     <= lt;
      req_empty_word <= emp;
      req_last       <= lst;
      req_valid      <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (trie_walk(op, lt, emp, lst, res)) pending_answers.push_back(res);
      items_sent++;
      gap = calm ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_word(op_type op);
      if (word_len == 0) begin
         send_item(op, '0, 1'b1, 1'b1);
      end else begin
         for (int i = 0; i < word_len; i++)
            send_item(op, word_buf[i], 1'b0, i == word_len - 1);
      end
   endtask

   task automatic make_random_word(int max_len);
      int top;
      top = $urandom_range(0, 1) ? 3 : ALPHABET - 1;
      word_len = $urandom_range(1, max_len);
      for (int i = 0; i < word_len; i++)
         word_buf[i] = letter_type'($urandom_range(0, top));
   endtask

   task automatic save_to_bank();
      int slot;
      slot = (bank_count < BANK_SIZE) ? bank_count : $urandom_range(0, BANK_SIZE - 1);
      if (bank_count < BANK_SIZE) bank_count++;
      bank_len[slot] = word_len;
      for (int i = 0; i < word_len; i++) bank_letters[slot][i] = word_buf[i];
   endtask

   // Copy a banked word, optionally cut down to one of its prefixes; with an empty bank, make a random word.
   task automatic pick_bank_word(bit trim);
      int slot;
      if (bank_count == 0) begin
         make_random_word(6);
      end else begin
         slot = $urandom_range(0, bank_count - 1);
         word_len = bank_len[slot];
         for (int i = 0; i < word_len; i++) word_buf[i] = bank_letters[slot][i];
         if (trim) word_len = $urandom_range(1, word_len);
      end
   endtask

   // Arbitrary field values, closed by a last mark so the next word starts clean.
   task automatic send_noise_word();
      int n;
      n = $urandom_range(0, 4);
      repeat (n)
         send_item(op_type'($urandom_range(0, 3)), letter_type'($urandom_range(0, 31)),
                   $urandom_range(0, 9) == 0, 1'b0);
      send_item(op_type'($urandom_range(0, 3)), letter_type'($urandom_range(0, 31)),
                1'($urandom_range(0, 1)), 1'b1);
   endtask

   task automatic test_empty_words();
      send_item(OP_SEARCH, 5'd0, 1'b1, 1'b1);
      send_item(OP_INSERT, 5'd31, 1'b1, 1'b0);
      send_item(OP_SEARCH, 5'd17, 1'b1, 1'b0);
      send_item(OP_PREFIX, 5'd0, 1'b1, 1'b1);
   endtask

   task automatic test_letter_extremes();
      send_item(OP_INSERT, 5'd0, 1'b0, 1'b0);
      send_item(OP_INSERT, 5'd25, 1'b0, 1'b1);
      send_item(OP_SEARCH, 5'd0, 1'b0, 1'b0);
      send_item(OP_SEARCH, 5'd25, 1'b0, 1'b1);
      send_item(OP_SEARCH, 5'd0, 1'b0, 1'b1);
      send_item(OP_PREFIX, 5'd0, 1'b0, 1'b1);
   endtask

   task automatic test_out_of_range();
      send_item(OP_INSERT, 5'd0, 1'b0, 1'b0);
      send_item(OP_INSERT, 5'd31, 1'b0, 1'b0);
      send_item(OP_INSERT, 5'd26, 1'b0, 1'b1);
      send_item(OP_SEARCH, 5'd0, 1'b0, 1'b1);
   endtask

   task automatic test_empty_mid_word();
      send_item(OP_SEARCH, 5'd0, 1'b0, 1'b0);
      send_item(OP_SEARCH, 5'd9, 1'b1, 1'b0);
   endtask

   task automatic test_mixed_ops();
      send_item(OP_PREFIX, 5'd1, 1'b0, 1'b0);
      send_item(OP_INSERT, 5'd2, 1'b0, 1'b1);
      send_item(OP_INSERT, 5'd1, 1'b0, 1'b0);
      send_item(OP_SEARCH, 5'd2, 1'b0, 1'b1);
      send_item(OP_SPARE, 5'd1, 1'b0, 1'b1);
   endtask

   task automatic test_random_words(int count);
      int stop_at;
      int r;
      stop_at = items_sent + count;
      while (items_sent < stop_at) begin
         // Leave every fifth stretch free of gaps and stalls.
         calm = ((items_sent / 128) % 5) == 4;
         r = $urandom_range(0, 99);
         if (r < 30) begin
            make_random_word($urandom_range(0, 9) == 0 ? 12 : 6);
            save_to_bank();
            send_word(OP_INSERT);
         end else if (r < 55) begin
            pick_bank_word($urandom_range(0, 3) == 0);
            send_word(OP_SEARCH);
         end else if (r < 72) begin
            pick_bank_word(1'b1);
            send_word(OP_PREFIX);
         end else if (r < 85) begin
            make_random_word(6);
            send_word($urandom_range(0, 1) ? OP_SEARCH : OP_PREFIX);
         end else begin
            send_noise_word();
         end
      end
      calm = 1'b0;
   endtask

   // Insert long fresh words until the pool is spent, then a few past it.
   task automatic test_pool_exhaustion();
      while (used_count < NODES) begin
         word_len = 8;
         for (int i = 0; i < word_len; i++)
            word_buf[i] = letter_type'($urandom_range(0, ALPHABET - 1));
         if ($urandom_range(0, 7) == 0) save_to_bank();
         send_word(OP_INSERT);
      end
      repeat (6) begin
         make_random_word(8);
         send_word(OP_INSERT);
         send_word(OP_SEARCH);
         send_word(OP_PREFIX);
      end
   endtask

   always @(posedge clock) begin
      if (stall_run == 0) begin
         if (calm || $urandom_range(0, 1)) begin
            stall_on = 1'b0;
            stall_run = $urandom_range(1, 16);
         end else begin
            stall_on = 1'b1;
            stall_run = pick_gap() + 1;
         end
      end
      stall_run--;
      rsp_stall <= stall_on;
   end

   always @(posedge clock) begin
      answer_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_answers.size() == 0) begin
            report_mismatch($sformatf("response with none pending (answer %0b, overflow %0b)",
                                      rsp_answer, rsp_out_of_nodes));
         end else begin
            want = pending_answers.pop_front();
            if (rsp_answer !== want.answer)
               report_mismatch($sformatf("answer got %0b want %0b", rsp_answer, want.answer));
            if (rsp_out_of_nodes !== want.out_of_nodes)
               report_mismatch($sformatf("out_of_nodes got %0b want %0b",
                                         rsp_out_of_nodes, want.out_of_nodes));
         end
      end
   end

   initial begin
      for (int i = 0; i < NODES * ALPHABET; i++) link_mem[i] = '0;
      for (int i = 0; i < NODES; i++) end_mem[i] = 1'b0;
      used_count = 1;
      cur_node = '0;
      walk_missed = 1'b0;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_empty_words();
      test_letter_extremes();
      test_out_of_range();
      test_empty_mid_word();
      test_mixed_ops();
      test_random_words(900);
      test_pool_exhaustion();
      test_random_words(300);

      req_valid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      #15_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
